/* src/zph_pkg.sv */
// Shared types and constants for the Zobrist position hash block.
// No dependencies; imported by zph_front, zph_mixer, zph_back and zobrist_position_hash.
`timescale 1ns / 1ps
`default_nettype none

package zph_pkg;

    localparam int ZPH_KEY_W = 10;

    // splitmix64 constants
    localparam logic [63:0] ZPH_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] ZPH_MUL1   = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] ZPH_MUL2   = 64'h94D049BB133111EB;
    localparam logic [63:0] ZPH_SEED   = 64'hC0FFEE123456789A;
    localparam int          ZPH_SHIFT1 = 30;
    localparam int          ZPH_SHIFT2 = 27;
    localparam int          ZPH_SHIFT3 = 31;

    // key numbering
    localparam logic [ZPH_KEY_W-1:0] ZPH_COLOR_STRIDE = 10'd384;
    localparam logic [ZPH_KEY_W-1:0] ZPH_SIDE_KEY     = 10'd768;
    localparam logic [ZPH_KEY_W-1:0] ZPH_CASTLE_KEY   = 10'd769;
    localparam logic [ZPH_KEY_W-1:0] ZPH_EP_KEY       = 10'd773;
    localparam logic [2:0]           ZPH_NUM_TYPES    = 3'd6;

    localparam int ZPH_CMD_DEPTH = 4;
    localparam int ZPH_OUT_DEPTH = 2;

    // what happens to the accumulator when a key comes out of the mixer
    typedef struct packed {
        logic xor_en;
        logic emit;
    } t_tag;

    typedef struct packed {
        logic [ZPH_KEY_W-1:0] key_num;
        t_tag                 tag;
    } t_cmd;

    function automatic logic [63:0] zph_mul32(input logic [31:0] a, input logic [31:0] b);
        return {32'h0, a} * {32'h0, b};
    endfunction

endpackage

`default_nettype wire

/* src/zph_fifo.sv */
// Small register-based FIFO, used for the command queue and the result queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module zph_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             w_push_ok, w_pop_ok;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd];
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push_ok && !w_pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop_ok && !w_push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* src/zph_front.sv */
// Front end: takes one square per transaction and breaks it into key commands.
// Depends on zph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zph_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    output logic              o_full,
    input  wire logic [2:0]   i_row,
    input  wire logic [2:0]   i_col,
    input  wire logic         i_occupied,
    input  wire logic         i_piece_color,
    input  wire logic [2:0]   i_piece_type,
    input  wire logic         i_last,
    input  wire logic         i_black_to_move,
    input  wire logic [3:0]   i_castling_rights,
    input  wire logic         i_ep_valid,
    input  wire logic [2:0]   i_ep_file,
    output zph_pkg::t_cmd     o_cmd,
    output logic              o_cmd_push,
    input  wire logic         i_cmd_full
);
    import zph_pkg::*;

    // pending bits: piece, side, castle 0..3, en passant
    logic       r_busy, n_busy;
    logic [6:0] r_pend, n_pend;
    logic       r_last, n_last;
    logic [2:0] r_row, r_col, r_type, r_ep_file;
    logic       r_color;
    logic [6:0] w_low, w_rest;
    logic       w_accept, w_piece;

    assign o_full   = r_busy;
    assign w_accept = i_push && !r_busy;
    assign w_piece  = i_occupied && (i_piece_type < ZPH_NUM_TYPES);
    assign w_low    = r_pend & (~r_pend + 7'd1);
    assign w_rest   = r_pend & ~w_low;

    always_comb begin
        n_busy     = r_busy;
        n_pend     = r_pend;
        n_last     = r_last;
        o_cmd_push = 1'b0;
        o_cmd      = '0;

        priority if (r_pend[0]) begin
            o_cmd.key_num = {1'b0, r_type, r_row, r_col} + (r_color ? ZPH_COLOR_STRIDE : '0);
        end else if (r_pend[1]) begin
            o_cmd.key_num = ZPH_SIDE_KEY;
        end else if (r_pend[2]) begin
            o_cmd.key_num = ZPH_CASTLE_KEY;
        end else if (r_pend[3]) begin
            o_cmd.key_num = ZPH_CASTLE_KEY + 10'd1;
        end else if (r_pend[4]) begin
            o_cmd.key_num = ZPH_CASTLE_KEY + 10'd2;
        end else if (r_pend[5]) begin
            o_cmd.key_num = ZPH_CASTLE_KEY + 10'd3;
        end else if (r_pend[6]) begin
            o_cmd.key_num = ZPH_EP_KEY + {7'h0, r_ep_file};
        end else begin
            o_cmd.key_num = '0;
        end
        o_cmd.tag.xor_en = (r_pend != '0);
        o_cmd.tag.emit   = r_last && (w_rest == '0);

        if (w_accept) begin
            n_pend = {i_ep_valid && i_last, i_castling_rights & {4{i_last}},
                      i_black_to_move && i_last, w_piece};
            n_last = i_last;
            n_busy = i_last || w_piece;
        end else if (r_busy && !i_cmd_full) begin
            o_cmd_push = 1'b1;
            n_pend     = w_rest;
            if (w_rest == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= '0;
            r_last <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pend <= n_pend;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_row     <= i_row;
            r_col     <= i_col;
            r_color   <= i_piece_color;
            r_type    <= i_piece_type;
            r_ep_file <= i_ep_file;
        end
    end

endmodule

`default_nettype wire

/* src/zph_mixer.sv */
// Pipelined splitmix64 key generator, one key number in per cycle, 7 stages.
// 64-bit products are built from 32x32 partial products. Depends on zph_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zph_mixer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire zph_pkg::t_cmd i_cmd,
    output logic               o_valid,
    output logic [63:0]        o_key,
    output zph_pkg::t_tag      o_tag
);
    import zph_pkg::*;

    localparam int STAGES = 7;

    logic [STAGES-1:0] r_v;
    t_tag              r_tag [STAGES];
    logic [31:0]       w_n1;
    logic [63:0]       w_x1, w_x2;

    logic [63:0] r_g_lo, r_z0, r_p0a, r_z1, r_p0b, r_z2, r_key;
    logic [31:0] r_g_hi, r_p1a, r_p2a, r_p1b, r_p2b;

    assign w_n1 = {22'h0, i_cmd.key_num} + 32'd1;
    assign w_x1 = r_z0 ^ (r_z0 >> ZPH_SHIFT1);
    assign w_x2 = r_z1 ^ (r_z1 >> ZPH_SHIFT2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_cmd.tag;
        for (int s = 1; s < STAGES; s++) begin
            r_tag[s] <= r_tag[s-1];
        end
        // (n+1) * golden
        r_g_lo <= zph_mul32(w_n1, ZPH_GOLDEN[31:0]);
        r_g_hi <= w_n1 * ZPH_GOLDEN[63:32];
        r_z0   <= ZPH_SEED + r_g_lo + {r_g_hi, 32'h0};
        // first multiply, low 64 bits only
        r_p0a  <= zph_mul32(w_x1[31:0], ZPH_MUL1[31:0]);
        r_p1a  <= w_x1[63:32] * ZPH_MUL1[31:0];
        r_p2a  <= w_x1[31:0] * ZPH_MUL1[63:32];
        r_z1   <= r_p0a + {r_p1a + r_p2a, 32'h0};
        // second multiply
        r_p0b  <= zph_mul32(w_x2[31:0], ZPH_MUL2[31:0]);
        r_p1b  <= w_x2[63:32] * ZPH_MUL2[31:0];
        r_p2b  <= w_x2[31:0] * ZPH_MUL2[63:32];
        r_z2   <= r_p0b + {r_p1b + r_p2b, 32'h0};
        r_key  <= r_z2 ^ (r_z2 >> ZPH_SHIFT3);
    end

    assign o_valid = r_v[STAGES-1];
    assign o_key   = r_key;
    assign o_tag   = r_tag[STAGES-1];

endmodule

`default_nettype wire

/* src/zph_back.sv */
// Back end: issues queued commands to the mixer, folds keys into the
// accumulator and queues finished hashes. Depends on zph_pkg, zph_mixer, zph_fifo.
`timescale 1ns / 1ps
`default_nettype none

module zph_back #(
    parameter int OUT_DEPTH = zph_pkg::ZPH_OUT_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire zph_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    output logic [63:0]        o_hash,
    output logic               o_empty,
    input  wire logic          i_pop
);
    import zph_pkg::*;

    localparam int CW = $clog2(OUT_DEPTH + 1);

    // hashes promised to the result queue: in flight in the mixer or waiting there
    logic [CW-1:0] r_credit;
    logic [63:0]   r_acc;
    logic [63:0]   w_acc_next, w_key;
    logic          w_key_valid, w_out_full, w_out_pop, w_emit_issue;
    t_tag          w_tag;

    assign o_cmd_pop    = !i_cmd_empty && (!i_cmd.tag.emit || (r_credit < CW'(OUT_DEPTH)));
    assign w_emit_issue = o_cmd_pop && i_cmd.tag.emit;
    assign w_out_pop    = i_pop && !o_empty;
    assign w_acc_next   = r_acc ^ (w_tag.xor_en ? w_key : 64'h0);

    zph_mixer u_mixer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (o_cmd_pop),
        .i_cmd   (i_cmd),
        .o_valid (w_key_valid),
        .o_key   (w_key),
        .o_tag   (w_tag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_credit <= '0;
        end else begin
            if (w_key_valid) begin
                r_acc <= w_tag.emit ? 64'h0 : w_acc_next;
            end
            if (w_emit_issue && !w_out_pop) begin
                r_credit <= r_credit + 1'b1;
            end else if (w_out_pop && !w_emit_issue) begin
                r_credit <= r_credit - 1'b1;
            end
        end
    end

    zph_fifo #(
        .WIDTH (64),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_key_valid && w_tag.emit),
        .i_data  (w_acc_next),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_data  (o_hash),
        .o_empty (o_empty)
    );

`ifndef SYNTHESIS
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_key_valid && w_tag.emit) |-> !w_out_full)
        else $error("result queue overflow");
`endif

endmodule

`default_nettype wire

/* src/zobrist_position_hash.sv */
// Zobrist position hash: one board square per transaction, hash out on the
// square marked last. Keys come from a 7-stage splitmix64 pipeline (two 64-bit
// products built from 32x32 partial products). The front end takes a square,
// then issues one key command per cycle into a short queue while it has room:
// an empty non-last square leaves the front end free, an occupied one holds it
// for its piece command, the last square for one command per key it needs
// (piece, side, castling bits, en passant; at most 7, or one if none). The back
// end drains one key per cycle; a final command waits for result queue room.
// Depends on zph_pkg, zph_front, zph_fifo, zph_back.
`timescale 1ns / 1ps
`default_nettype none

module zobrist_position_hash #(
    parameter int CMD_DEPTH = zph_pkg::ZPH_CMD_DEPTH,
    parameter int OUT_DEPTH = zph_pkg::ZPH_OUT_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [2:0]   i_row,
    input  wire logic [2:0]   i_col,
    input  wire logic         i_occupied,
    input  wire logic         i_piece_color,
    input  wire logic [2:0]   i_piece_type,
    input  wire logic         i_last,
    input  wire logic         i_black_to_move,
    input  wire logic [3:0]   i_castling_rights,
    input  wire logic         i_ep_valid,
    input  wire logic [2:0]   i_ep_file,
    output logic              empty,
    input  wire logic         pop,
    output logic [63:0]       o_hash
);
    import zph_pkg::*;

    t_cmd w_front_cmd, w_cmd_head;
    logic w_cmd_push, w_cmd_full, w_cmd_pop, w_cmd_empty;

    zph_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_row             (i_row),
        .i_col             (i_col),
        .i_occupied        (i_occupied),
        .i_piece_color     (i_piece_color),
        .i_piece_type      (i_piece_type),
        .i_last            (i_last),
        .i_black_to_move   (i_black_to_move),
        .i_castling_rights (i_castling_rights),
        .i_ep_valid        (i_ep_valid),
        .i_ep_file         (i_ep_file),
        .o_cmd             (w_front_cmd),
        .o_cmd_push        (w_cmd_push),
        .i_cmd_full        (w_cmd_full)
    );

    zph_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_front_cmd),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_head),
        .o_empty (w_cmd_empty)
    );

    zph_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_head),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_hash      (o_hash),
        .o_empty     (empty),
        .i_pop       (pop)
    );

`ifndef SYNTHESIS
    a_cmd_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> !w_cmd_full)
        else $error("command queue overflow");

    a_cmd_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty)
        else $error("command queue underflow");

    a_last_holds_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && i_last) |=> full)
        else $error("last square did not occupy the front end");

    a_empty_square_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && !i_last && !i_occupied) |=> !full)
        else $error("empty square stalled the front end");
`endif

endmodule

`default_nettype wire
